// ===== src/vn3_pkg.sv =====
// vn3_pkg: shared constants, payload types and status structs for the value noise block
// no dependencies
package vn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] MUL_X   = 32'h8da6b343;
    localparam logic [31:0] MUL_Y   = 32'hd8163841;
    localparam logic [31:0] MUL_Z   = 32'hcb1ab31f;
    localparam logic [31:0] MUL_MIX = 32'h7feb352d;

    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [VAL_W-1:0]     val_t;

    // one classified point: cell corner and fractions
    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        frac_t       fx;
        frac_t       fy;
        frac_t       fz;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic pop;
    } bk_status_t;

endpackage

// ===== src/vn3_front.sv =====
// vn3_front: input register that splits each coordinate into cell and fraction
// depends on vn3_pkg
module vn3_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pos_valid,
    output logic                 pos_stall,
    input  logic [31:0]          pos_x,
    input  logic [31:0]          pos_y,
    input  logic [31:0]          pos_z,
    input  vn3_pkg::q_status_t   q_st,
    output logic                 push,
    output vn3_pkg::item_t       push_item
);

    logic           valid_reg;
    logic           valid_next;
    vn3_pkg::item_t item_reg;
    logic           take;

    assign pos_stall = valid_reg && q_st.full;
    assign push      = valid_reg && !q_st.full;
    assign take      = pos_valid && !pos_stall;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // floor is an arithmetic shift, fraction the low bits
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cx <= 32'($signed(pos_x) >>> vn3_pkg::FRAC_BITS);
            item_reg.cy <= 32'($signed(pos_y) >>> vn3_pkg::FRAC_BITS);
            item_reg.cz <= 32'($signed(pos_z) >>> vn3_pkg::FRAC_BITS);
            item_reg.fx <= pos_x[vn3_pkg::FRAC_BITS-1:0];
            item_reg.fy <= pos_y[vn3_pkg::FRAC_BITS-1:0];
            item_reg.fz <= pos_z[vn3_pkg::FRAC_BITS-1:0];
        end
    end

endmodule

// ===== src/vn3_queue.sv =====
// vn3_queue: short fifo between front and back
// depends on vn3_pkg
module vn3_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vn3_pkg::item_t     push_item,
    input  logic               pop,
    output vn3_pkg::item_t     head,
    output vn3_pkg::q_status_t q_st
);

    vn3_pkg::item_t                mem [vn3_pkg::QUEUE_DEPTH];
    logic [vn3_pkg::QPTR_W-1:0]    wr_reg;
    logic [vn3_pkg::QPTR_W-1:0]    rd_reg;
    logic [vn3_pkg::QPTR_W:0]      cnt_reg;
    logic [vn3_pkg::QPTR_W:0]      cnt_next;

    assign q_st.full  = (cnt_reg == (vn3_pkg::QPTR_W+1)'(vn3_pkg::QUEUE_DEPTH));
    assign q_st.empty = (cnt_reg == '0);
    assign head       = mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

// ===== src/vn3_back.sv =====
// vn3_back: hash, smoothstep and trilinear blend pipeline with output register
// depends on vn3_pkg
module vn3_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          seed,
    input  vn3_pkg::item_t       head,
    input  vn3_pkg::q_status_t   q_st,
    output vn3_pkg::bk_status_t  bk_st,
    output logic                 noise_valid,
    input  logic                 noise_stall,
    output logic [23:0]          noise_value
);

    localparam int F = vn3_pkg::FRAC_BITS;

    function automatic vn3_pkg::val_t blend(vn3_pkg::val_t a, vn3_pkg::val_t b,
                                            vn3_pkg::frac_t u);
        logic [F:0]      w;
        logic [24+F:0]   p0;
        logic [24+F:0]   p1;
        logic [25+F:0]   s;
        w  = (F+1)'(1 << F) - {1'b0, u};
        p0 = (25+F)'(a * w);
        p1 = (25+F)'(b * u);
        s  = {1'b0, p0} + {1'b0, p1};
        return s[F+23:F];
    endfunction

    logic [4:0] v_reg;
    logic       out_valid_reg;
    logic       adv;

    // stage 1
    logic [31:0]    ax_reg, ay_reg, az_reg;
    vn3_pkg::frac_t f_reg [3];
    vn3_pkg::frac_t f2_reg [3];
    // stage 2
    logic [31:0]    h2_reg [8];
    vn3_pkg::frac_t u2_reg [3];
    // stage 3
    logic [31:0]    hm_reg [8];
    vn3_pkg::frac_t u3_reg [3];
    // stage 4
    vn3_pkg::val_t  rx_reg [4];
    vn3_pkg::frac_t uy4_reg, uz4_reg;
    // stage 5
    vn3_pkg::val_t  ry_reg [2];
    vn3_pkg::frac_t uz5_reg;
    vn3_pkg::val_t  out_reg;

    vn3_pkg::frac_t fin [3];
    logic [31:0]    hpre [8];
    vn3_pkg::val_t  cv [8];
    vn3_pkg::frac_t ucalc [3];

    assign adv         = !out_valid_reg || !noise_stall;
    assign bk_st.pop   = adv && !q_st.empty;
    assign noise_valid = out_valid_reg;
    assign noise_value = out_reg;

    assign fin[0] = head.fx;
    assign fin[1] = head.fy;
    assign fin[2] = head.fz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[3:0], !q_st.empty};
            out_valid_reg <= v_reg[4];
        end
    end

    // corner hash before the mixing multiply; +1 cell is the product plus its constant
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            logic [31:0] hx, hy, hz, h;
            hx = c[0] ? ax_reg + vn3_pkg::MUL_X : ax_reg;
            hy = c[1] ? ay_reg + vn3_pkg::MUL_Y : ay_reg;
            hz = c[2] ? az_reg + vn3_pkg::MUL_Z : az_reg;
            h  = seed ^ hx ^ hy ^ hz;
            hpre[c] = h ^ (h >> 16);
        end
        for (int k = 0; k < 3; k++)
        begin
            logic [F+1:0]   t;
            logic [2*F+1:0] p;
            t = (F+2)'(3 << F) - {1'b0, f_reg[k], 1'b0};
            p = (2*F+2)'(f2_reg[k] * t);
            ucalc[k] = p[2*F-1:F];
        end
        for (int c = 0; c < 8; c++)
        begin
            logic [31:0] m;
            m = hm_reg[c] ^ (hm_reg[c] >> 15);
            cv[c] = m[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= head.cx * vn3_pkg::MUL_X;
            ay_reg <= head.cy * vn3_pkg::MUL_Y;
            az_reg <= head.cz * vn3_pkg::MUL_Z;
            for (int k = 0; k < 3; k++)
            begin
                logic [2*F-1:0] sq;
                sq = fin[k] * fin[k];
                f_reg[k]  <= fin[k];
                f2_reg[k] <= sq[2*F-1:F];
            end
            for (int c = 0; c < 8; c++)
            begin
                h2_reg[c] <= hpre[c];
                hm_reg[c] <= h2_reg[c] * vn3_pkg::MUL_MIX;
            end
            for (int k = 0; k < 3; k++)
            begin
                u2_reg[k] <= ucalc[k];
                u3_reg[k] <= u2_reg[k];
            end
            for (int j = 0; j < 4; j++)
            begin
                rx_reg[j] <= blend(cv[2*j], cv[2*j+1], u3_reg[0]);
            end
            uy4_reg <= u3_reg[1];
            uz4_reg <= u3_reg[2];
            for (int j = 0; j < 2; j++)
            begin
                ry_reg[j] <= blend(rx_reg[2*j], rx_reg[2*j+1], uy4_reg);
            end
            uz5_reg <= uz4_reg;
            out_reg <= blend(ry_reg[0], ry_reg[1], uz5_reg);
        end
    end

endmodule

// ===== src/value_noise_3d_top.sv =====
// value_noise_3d_top: top level of the 3d value noise block
// depends on vn3_pkg, vn3_front, vn3_queue, vn3_back
//
// 3d value noise: each point (Q15.16 per axis) is split into a cell and a
// fraction, the eight corners are hashed with noise_seed and blended with
// smoothstep weights into a Q0.24 value. one point is accepted per cycle while
// the queue has room; results leave at that rate while noise_stall is low. a
// result passes the queue write, coordinate multiplies, hash fold, mixing
// multiply and three blend levels (the last is the output register) after its
// point enters the front register. the four-entry queue lets the front keep
// taking points for a while when the output side stalls. the user writes
// noise_seed only while idle, on its own always-ready channel; no block check.
module value_noise_3d_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pos_valid,
    output logic        pos_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    output logic        noise_valid,
    input  logic        noise_stall,
    output logic [23:0] noise_value,
    input  logic        noise_seed_valid,
    output logic        noise_seed_ready,
    input  logic [31:0] noise_seed
);

    // configuration register
    logic [31:0] seed_reg;

    vn3_pkg::q_status_t  q_st;
    vn3_pkg::bk_status_t bk_st;
    vn3_pkg::item_t      push_item;
    vn3_pkg::item_t      head;
    logic                push;

    assign noise_seed_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (noise_seed_valid && noise_seed_ready)
        begin
            seed_reg <= noise_seed;
        end
    end

    // front: cell and fraction split
    vn3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_valid (pos_valid),
        .pos_stall (pos_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .q_st      (q_st),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    vn3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (bk_st.pop),
        .head      (head),
        .q_st      (q_st)
    );

    // back: hash and blend pipeline
    vn3_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .head        (head),
        .q_st        (q_st),
        .bk_st       (bk_st),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value)
    );

`ifndef SYNTH
    // queue can never report full and empty together
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_st.full && q_st.empty))
        else $error("queue full and empty at once");

    // a pop only happens from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_st.pop |-> !q_st.empty)
        else $error("pop from empty queue");

    // full queue with no pop stays full next cycle
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_st.full && !bk_st.pop) |=> q_st.full)
        else $error("full queue drained without pop");
`endif

endmodule

// ===== dv/value_noise_3d_top_tb.sv =====
// value_noise_3d_top_tb: self-checking bench for the 3d value noise block
// drives points with random idling and stalls, predicts each noise value in-bench
// depends on vn3_pkg and value_noise_3d_top
module value_noise_3d_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_POINTS = 1300;
    localparam int unsigned SETTLE_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        pos_valid;
    logic        pos_stall;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        noise_valid;
    logic        noise_stall;
    logic [23:0] noise_value;
    logic        noise_seed_valid;
    logic        noise_seed_ready;
    logic [31:0] noise_seed;

    value_noise_3d_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .pos_valid        (pos_valid),
        .pos_stall        (pos_stall),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .noise_valid      (noise_valid),
        .noise_stall      (noise_stall),
        .noise_value      (noise_value),
        .noise_seed_valid (noise_seed_valid),
        .noise_seed_ready (noise_seed_ready),
        .noise_seed       (noise_seed)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // bench copy of the seed register
    logic [31:0] seed_shadow;
    // expected noise values, oldest first
    vn3_pkg::val_t expected_noise[$];
    int unsigned mismatch_count;
    int unsigned noise_seen;
    int unsigned cycle_count;
    bit          quiet_phase;   // when set neither side idles

    // directed points: coordinate triple and an optional known result
    typedef struct {
        logic [31:0]   x;
        logic [31:0]   y;
        logic [31:0]   z;
        bit            known;
        vn3_pkg::val_t want;
    } point_t;

    // ---------------- predictor ----------------
    function automatic logic [23:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] cz);
        logic [31:0] h;
        h = seed_shadow ^ (cx * 32'h8da6b343) ^ (cy * 32'hd8163841) ^ (cz * 32'hcb1ab31f);
        h = h ^ (h >> 16);
        h = h * 32'h7feb352d;
        h = h ^ (h >> 15);
        return h[23:0];
    endfunction

    // smoothstep weight of the fraction bits, Q0.16
    function automatic logic [63:0] smooth_weight(logic [31:0] v);
        logic [63:0] f;
        logic [63:0] f2;
        f  = {48'd0, v[vn3_pkg::FRAC_BITS-1:0]};
        f2 = (f * f) >> vn3_pkg::FRAC_BITS;
        return (f2 * ((64'd3 << vn3_pkg::FRAC_BITS) - 2 * f)) >> vn3_pkg::FRAC_BITS;
    endfunction

    function automatic logic [63:0] lerp_q24(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] w);
        return (a * ((64'd1 << vn3_pkg::FRAC_BITS) - w) + b * w) >> vn3_pkg::FRAC_BITS;
    endfunction

    function automatic vn3_pkg::val_t predict_noise(logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz);
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] zz;
        logic [63:0] wx;
        logic [63:0] wy;
        logic [63:0] wz;
        logic [63:0] row0;
        logic [63:0] row1;
        logic [63:0] plane[2];
        logic [63:0] mixed;
        cx = $unsigned($signed(px) >>> vn3_pkg::FRAC_BITS);
        cy = $unsigned($signed(py) >>> vn3_pkg::FRAC_BITS);
        cz = $unsigned($signed(pz) >>> vn3_pkg::FRAC_BITS);
        wx = smooth_weight(px);
        wy = smooth_weight(py);
        wz = smooth_weight(pz);
        for (int k = 0; k < 2; k++)
        begin
            zz   = cz + k;   // wraps at the top of the range
            row0 = lerp_q24(corner_hash(cx, cy, zz), corner_hash(cx + 1, cy, zz), wx);
            row1 = lerp_q24(corner_hash(cx, cy + 1, zz),
                            corner_hash(cx + 1, cy + 1, zz), wx);
            plane[k] = lerp_q24(row0, row1, wy);
        end
        mixed = lerp_q24(plane[0], plane[1], wz);
        return mixed[23:0];
    endfunction

    // ---------------- input side ----------------
    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 9);
    endfunction

    // present one point and hold it until the block takes it
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              bit known = 1'b0, vn3_pkg::val_t want = '0);
        while (idle_now())
        begin
            pos_valid <= 1'b0;
            @(posedge clk);
        end
        pos_valid <= 1'b1;
        pos_x     <= px;
        pos_y     <= py;
        pos_z     <= pz;
        @(posedge clk);
        while (pos_stall)
            @(posedge clk);
        // transaction taken at this edge
        expected_noise = {expected_noise, known ? want : predict_noise(px, py, pz)};
    endtask

    task automatic drop_valid();
        pos_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        drop_valid();
        while (expected_noise.size() != 0)
            @(posedge clk);
    endtask

    // seed written only while the block is idle
    task automatic write_seed(logic [31:0] value);
        drain_results();
        noise_seed_valid <= 1'b1;
        noise_seed       <= value;
        @(posedge clk);
        while (!noise_seed_ready)
            @(posedge clk);
        noise_seed_valid <= 1'b0;
        seed_shadow = value;
        @(posedge clk);
    endtask

    // random coordinate: near the origin, near the range extremes, or anywhere
    function automatic logic [31:0] random_coord();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            2:       return {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom())};
            default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    // ---------------- output side ----------------
    always @(posedge clk)
    begin
        if (rst_n)
            noise_stall <= idle_now();
    end

    always @(posedge clk)
    begin
        if (rst_n && noise_valid && !noise_stall)
        begin
            noise_seen++;
            if (expected_noise.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected noise transaction: value %06h", noise_value);
            end
            else
            begin
                vn3_pkg::val_t want;
                want = expected_noise.pop_front();
                if (noise_value !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("noise_value mismatch: expected %06h actual %06h",
                                 want, noise_value);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    point_t directed[$];
    int unsigned settle;

    initial
    begin
        rst_n            = 1'b0;
        pos_valid        = 1'b0;
        pos_x            = '0;
        pos_y            = '0;
        pos_z            = '0;
        noise_stall      = 1'b0;
        noise_seed_valid = 1'b0;
        noise_seed       = '0;
        seed_shadow      = '0;
        mismatch_count   = 0;
        noise_seen       = 0;
        cycle_count      = 0;
        quiet_phase      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: origin, extremes, negative fractions, wrapping cells
        // at seed zero the origin hashes cell (0,0,0) to zero with zero weights
        directed = '{
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 24'h000000},
            '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, 24'h000000},
            '{32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff, 1'b0, 24'h000000},
            '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 24'h000000},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 24'h000000},
            '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 24'h000000},
            '{32'hffff_0000, 32'h0001_0000, 32'hfffe_8000, 1'b0, 24'h000000},
            '{32'h7fff_0000, 32'h8000_ffff, 32'h0000_0001, 1'b0, 24'h000000},
            '{32'h0001_0000, 32'h0000_0000, 32'hffff_8000, 1'b0, 24'h000000},
            '{32'haaaa_aaaa, 32'h5555_5555, 32'hcccc_3333, 1'b0, 24'h000000},
            '{32'h0000_4000, 32'hffff_c000, 32'h7fff_ffff, 1'b0, 24'h000000}
        };
        foreach (directed[i])
            send_point(directed[i].x, directed[i].y, directed[i].z,
                       directed[i].known, directed[i].want);
        drain_results();

        // seed extremes then random seeds, with random points between
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       write_seed(32'hffff_ffff);
                1:       write_seed(32'h0000_0000);
                2:       write_seed(32'h8000_0001);
                default: write_seed($urandom());
            endcase
            quiet_phase = (phase == 3);   // one long stretch with no idling
            foreach (directed[i])
                if (i < 4)
                    send_point(directed[i].x, directed[i].y, directed[i].z);
            for (int n = 0; n < RANDOM_POINTS / 6; n++)
            begin
                send_point(random_coord(), random_coord(), random_coord());
                // hold off until the block has emptied
                if (n == 50)
                    drain_results();
            end
            quiet_phase = 1'b0;
        end

        drain_results();
        settle = 0;
        while (settle < SETTLE_CYCLES)
        begin
            @(posedge clk);
            settle++;
        end

        $display("covered %0d noise results over six seeds, seed extremes included",
                 noise_seen);
        if (mismatch_count == 0 && expected_noise.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
